// ===== hw/rtl/rlpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rlpl_pkg: shared types and constants for the longest prefix lookup unit
// Table size, field widths, opcodes, FSM states and the token that walks
// the chain of route cells.
// ============================================================================
package rlpl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 4;
    localparam int ENTRY_W     = 4;
    localparam int LEN_W       = 6;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // width used to compare a written slot number against a cell position
    localparam int CMP_W       = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } rlpl_state_t;

    // lookup token with the best route seen so far
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
    } rlpl_tok_t;

    // route entry written into one cell
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [PORT_W-1:0] port;
        logic              valid;
    } rlpl_route_t;

    // count of leading ones from the MSB; the highest zero bit sets it
    function automatic logic [LEN_W-1:0] mask_len(input logic [ADDR_W-1:0] m);
        logic [LEN_W-1:0] len;
        len = LEN_W'(ADDR_W);
        for (int i = 0; i < ADDR_W; i++) begin
            if (!m[i]) begin
                len = LEN_W'(ADDR_W - 1 - i);
            end
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rlpl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rlpl_cell: one route table entry of the lookup chain
// Stores one route and updates the passing lookup token when the route
// matches and is the first match or longer than the best one so far.
// ============================================================================
module rlpl_cell
    import rlpl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        wr_en,
    input  wire rlpl_route_t wr_route,
    input  wire rlpl_tok_t   tok_in,
    output      rlpl_tok_t   tok_out
);

    logic [ADDR_W-1:0] prefix_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [PORT_W-1:0] port_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              valid_reg;
    rlpl_tok_t         tok_reg;
    rlpl_tok_t         tok_next;
    logic              hit;
    logic              better;

    // length is precomputed at write time, off the lookup path
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prefix_reg <= wr_route.prefix;
            mask_reg   <= wr_route.mask;
            port_reg   <= wr_route.port;
            len_reg    <= mask_len(wr_route.mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= wr_route.valid;
        end
    end

    assign hit    = tok_in.valid && valid_reg &&
                    (((prefix_reg ^ tok_in.addr) & mask_reg) == '0);
    // strict compare keeps the lower index on a tie
    assign better = hit && (!tok_in.found || (len_reg > tok_in.len));

    always_comb begin
        tok_next = tok_in;
        if (better) begin
            tok_next.found = 1'b1;
            tok_next.len   = len_reg;
            tok_next.port  = port_reg;
        end
    end

    // only the token valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.addr  <= tok_next.addr;
        tok_reg.found <= tok_next.found;
        tok_reg.len   <= tok_next.len;
        tok_reg.port  <= tok_next.port;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/route_longest_prefix_lookup_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// route_longest_prefix_lookup_unit: IPv4 longest prefix match routing table
// A chain of route cells, one per table entry. Writes load one cell; a
// lookup token walks the chain and collects the longest matching route.
// ============================================================================
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  s_      | in  | s_valid/s_ready  | opcode, entry_index, route_prefix,
//          |     |                  | route_mask, route_port, route_valid,
//          |     |                  | lookup_addr
//  m_      | out | m_valid/m_ready  | found, out_port, match_len
//
//  One item is in flight at a time. A write item loads its cell on
//  acceptance, and its result then passes through ST_FIN into the output
//  register; a lookup's token moves one cell per cycle along the chain,
//  and its result is captured from the tail and then passes through ST_FIN
//  into the output register. A new item is taken once the result has moved.
//  Reset (aresetn low, synchronous) clears all route valid bits and the
//  control state; stored prefixes, masks and ports are not cleared.
//  The output register lets a new item enter while a result waits on
//  m_ready; a finished result is held until the output register frees up.
//
module route_longest_prefix_lookup_unit
    import rlpl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire logic                s_opcode,
    input  wire logic [ENTRY_W-1:0]  s_entry_index,
    input  wire logic [ADDR_W-1:0]   s_route_prefix,
    input  wire logic [ADDR_W-1:0]   s_route_mask,
    input  wire logic [PORT_W-1:0]   s_route_port,
    input  wire logic                s_route_valid,
    input  wire logic [ADDR_W-1:0]   s_lookup_addr,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      logic                m_found,
    output      logic [PORT_W-1:0]   m_out_port,
    output      logic [LEN_W-1:0]    m_match_len
);

    rlpl_state_t       state_reg;
    rlpl_state_t       state_next;

    logic              accept;
    logic              wr_fire;
    logic              lk_fire;
    logic              out_load;

    rlpl_route_t       wr_route;
    logic [TABLE_DEPTH-1:0] wr_sel;
    logic [TABLE_DEPTH-1:0] tok_valid_vec;
    rlpl_tok_t         tok [0:TABLE_DEPTH];
    rlpl_tok_t         tail;

    // finished result waiting for the output register
    logic              res_found_reg;
    logic [PORT_W-1:0] res_port_reg;
    logic [LEN_W-1:0]  res_len_reg;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_found_reg;
    logic [PORT_W-1:0] m_out_port_reg;
    logic [LEN_W-1:0]  m_match_len_reg;

    assign accept  = s_valid && s_ready;
    assign wr_fire = accept && (s_opcode == OP_WRITE);
    assign lk_fire = accept && (s_opcode == OP_LOOKUP);

    // ------------------------------------------------------------------
    // write broadcast: one cell selected by the slot number
    // ------------------------------------------------------------------
    assign wr_route.prefix = s_route_prefix;
    assign wr_route.mask   = s_route_mask;
    assign wr_route.port   = s_route_port;
    assign wr_route.valid  = s_route_valid;

    // chain head: a fresh token with no match yet
    assign tok[0].valid = lk_fire;
    assign tok[0].addr  = s_lookup_addr;
    assign tok[0].found = 1'b0;
    assign tok[0].len   = '0;
    assign tok[0].port  = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign wr_sel[g] = wr_fire && (CMP_W'(s_entry_index) == CMP_W'(g));

        rlpl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (wr_sel[g]),
            .wr_route (wr_route),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );

        assign tok_valid_vec[g] = tok[g+1].valid;
    end

    assign tail = tok[TABLE_DEPTH];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (lk_fire) begin
                    state_next = ST_WALK;
                end else if (wr_fire) begin
                    state_next = ST_FIN;
                end
            end
            ST_WALK: begin
                if (tail.valid) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_WALK: s_ready  = 1'b0;
            ST_FIN:  out_load = !m_valid_reg || m_ready;
            default: s_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // write items report no match
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            res_found_reg <= 1'b0;
            res_port_reg  <= '0;
            res_len_reg   <= '0;
        end else if ((state_reg == ST_WALK) && tail.valid) begin
            res_found_reg <= tail.found;
            res_port_reg  <= tail.port;
            res_len_reg   <= tail.len;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg     <= res_found_reg;
            m_out_port_reg  <= res_port_reg;
            m_match_len_reg <= res_len_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_out_port  = m_out_port_reg;
    assign m_match_len = m_match_len_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid_vec))
        else $error("more than one lookup token in the chain");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (tok_valid_vec == '0))
        else $error("token in the chain while idle");

    a_tail_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (state_reg == ST_WALK))
        else $error("token left the chain outside a walk");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail.valid && !tail.found) |-> ((tail.len == '0) && (tail.port == '0)))
        else $error("miss carries nonzero length or port");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && (state_next == ST_IDLE)) |=> m_valid_reg)
        else $error("finished result not presented");

endmodule
`default_nettype wire
